### rtl/core/sorted_set_operation_counter_assert.svh
// Assertion macros for the sorted set-operation counter.
// No dependencies; included by the files that carry assertions.
`ifndef SORTED_SET_OPERATION_COUNTER_ASSERT_SVH
`define SORTED_SET_OPERATION_COUNTER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define SSOC_ASSERT_NOW(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define SSOC_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

### rtl/core/ssoc_pkg.sv
// Shared types and constants for the sorted set-operation counter.
// No dependencies.
package ssoc_pkg;

    localparam int OP_WIDTH  = 3;
    localparam int RES_DEPTH = 4;

    localparam logic [OP_WIDTH-1:0] OP_INTERSECT     = 3'd0;
    localparam logic [OP_WIDTH-1:0] OP_INTERSECT_ALL = 3'd1;
    localparam logic [OP_WIDTH-1:0] OP_EXCEPT        = 3'd2;
    localparam logic [OP_WIDTH-1:0] OP_EXCEPT_ALL    = 3'd3;
    localparam logic [OP_WIDTH-1:0] OP_COMBINE       = 3'd4;

    typedef struct packed {
        logic [31:0] group_key;
        logic        side;
        logic        stream_end;
    } tuple_t;

    typedef struct packed {
        logic [31:0] result_key;
        logic [31:0] copies;
        logic        end_of_run;
    } result_t;

endpackage

### rtl/core/ssoc_copies.sv
// Copy-count selection for one closing group under the set operation.
// Depends on ssoc_pkg.
module ssoc_copies #(
    parameter int COUNT_WIDTH = 32
) (
    input  logic [ssoc_pkg::OP_WIDTH-1:0] set_operation,
    input  logic [COUNT_WIDTH-1:0]        left_count,
    input  logic [COUNT_WIDTH-1:0]        right_count,
    output logic [31:0]                   copies,
    output logic                          nonzero
);

    logic [COUNT_WIDTH-1:0] n;
    logic                   left_lt;

    assign left_lt = left_count < right_count;

    always_comb
    begin
        case (set_operation)
            ssoc_pkg::OP_INTERSECT:
                n = (left_count != '0 && right_count != '0) ? COUNT_WIDTH'(1) : '0;
            ssoc_pkg::OP_INTERSECT_ALL:
                n = left_lt ? left_count : right_count;
            ssoc_pkg::OP_EXCEPT:
                n = (left_count != '0 && right_count == '0) ? COUNT_WIDTH'(1) : '0;
            ssoc_pkg::OP_EXCEPT_ALL:
                n = left_lt ? '0 : left_count - right_count;
            ssoc_pkg::OP_COMBINE:
                n = COUNT_WIDTH'(1);
            default:
                n = '0;
        endcase
    end

    // clamp to the 32-bit result field
    assign copies  = (64'(n) > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : 32'(n);
    assign nonzero = n != '0;

endmodule

### rtl/core/sorted_set_operation_counter.sv
// Path: a tuple passes the input register and then the result queue before its first result is offered.
// Throughput: one tuple per cycle while the result queue holds at most two results; a tuple
// closing two groups costs two result transactions, buffered in a four-entry queue.
// Reset (rst_n low, asynchronous) empties the queue, closes the group, clears
// the counters and sets the operation to intersect.
// Depends on ssoc_pkg, ssoc_copies and sorted_set_operation_counter_assert.svh.
`include "sorted_set_operation_counter_assert.svh"

module sorted_set_operation_counter #(
    parameter int KEY_WIDTH   = 32,
    parameter int COUNT_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [ssoc_pkg::OP_WIDTH-1:0] cfg_data,
    input  logic                          tuple_valid,
    output logic                          tuple_stall,
    input  ssoc_pkg::tuple_t              tuple_data,
    output logic                          result_valid,
    input  logic                          result_stall,
    output ssoc_pkg::result_t             result_data
);

    localparam int KW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;
    localparam int PTR_W = $clog2(ssoc_pkg::RES_DEPTH);
    localparam int CNT_W = $clog2(ssoc_pkg::RES_DEPTH + 1);

    logic [ssoc_pkg::OP_WIDTH-1:0] set_op_reg;

    logic             in_valid_reg;
    ssoc_pkg::tuple_t in_reg;

    logic [KW-1:0]          key_reg,   key_next;
    logic [COUNT_WIDTH-1:0] left_reg,  left_next;
    logic [COUNT_WIDTH-1:0] right_reg, right_next;
    logic                   open_reg,  open_next;

    ssoc_pkg::result_t  queue_reg [ssoc_pkg::RES_DEPTH];
    logic [PTR_W-1:0]   rd_ptr_reg, wr_ptr_reg;
    logic [CNT_W-1:0]   count_reg,  count_next;

    logic [KW-1:0]          in_key;
    logic                   proc, close_old, fresh, pop;
    logic [COUNT_WIDTH-1:0] base_l, base_r;
    logic [31:0]            copies_old, copies_new;
    logic                   nz_old, nz_new, r0_valid, r1_valid;
    ssoc_pkg::result_t      r0, r1, first;
    logic [1:0]             push_n;

    // group logic
    assign in_key    = in_reg.group_key[KW-1:0];
    assign proc      = in_valid_reg && (count_reg <= CNT_W'(ssoc_pkg::RES_DEPTH - 2));
    assign close_old = open_reg && (in_key != key_reg);
    assign fresh     = !open_reg || close_old;
    assign base_l    = fresh ? '0 : left_reg;
    assign base_r    = fresh ? '0 : right_reg;

    always_comb
    begin
        key_next   = fresh ? in_key : key_reg;
        left_next  = base_l;
        right_next = base_r;
        if (in_reg.side)
            right_next = (base_r == '1) ? base_r : base_r + COUNT_WIDTH'(1);
        else
            left_next = (base_l == '1) ? base_l : base_l + COUNT_WIDTH'(1);
        open_next = !in_reg.stream_end;
    end

    ssoc_copies #(.COUNT_WIDTH(COUNT_WIDTH)) u_copies_old (
        .set_operation (set_op_reg),
        .left_count    (left_reg),
        .right_count   (right_reg),
        .copies        (copies_old),
        .nonzero       (nz_old)
    );

    ssoc_copies #(.COUNT_WIDTH(COUNT_WIDTH)) u_copies_new (
        .set_operation (set_op_reg),
        .left_count    (left_next),
        .right_count   (right_next),
        .copies        (copies_new),
        .nonzero       (nz_new)
    );

    assign r0_valid = close_old && nz_old;
    assign r1_valid = in_reg.stream_end && nz_new;

    always_comb
    begin
        r0.result_key = 32'(key_reg);
        r0.copies     = copies_old;
        r0.end_of_run = !r1_valid;
        r1.result_key = 32'(key_next);
        r1.copies     = copies_new;
        r1.end_of_run = 1'b1;
        first         = r0_valid ? r0 : r1;
        push_n        = proc ? (2'(r0_valid) + 2'(r1_valid)) : 2'd0;
    end

    // result queue
    assign pop          = result_valid && !result_stall;
    assign result_valid = count_reg != '0;
    assign result_data  = queue_reg[rd_ptr_reg];
    assign count_next   = count_reg + CNT_W'(push_n) - CNT_W'(pop);

    // input register
    assign tuple_stall = in_valid_reg && !proc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            set_op_reg   <= ssoc_pkg::OP_INTERSECT;
            in_valid_reg <= 1'b0;
            key_reg      <= '0;
            left_reg     <= '0;
            right_reg    <= '0;
            open_reg     <= 1'b0;
            rd_ptr_reg   <= '0;
            wr_ptr_reg   <= '0;
            count_reg    <= '0;
        end
        else
        begin
            if (cfg_write)
                set_op_reg <= cfg_data;
            if (!tuple_stall)
                in_valid_reg <= tuple_valid;
            if (proc)
            begin
                key_reg   <= key_next;
                left_reg  <= left_next;
                right_reg <= right_next;
                open_reg  <= open_next;
            end
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            wr_ptr_reg <= wr_ptr_reg + PTR_W'(push_n);
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!tuple_stall && tuple_valid)
            in_reg <= tuple_data;
        if (push_n != 2'd0)
            queue_reg[wr_ptr_reg] <= first;
        if (push_n == 2'd2)
            queue_reg[wr_ptr_reg + PTR_W'(1)] <= r1;
    end

    `SSOC_ASSERT_NOW(a_queue_bound, clk, rst_n, 1'b1,
        count_reg <= CNT_W'(ssoc_pkg::RES_DEPTH), "result queue overfilled")
    `SSOC_ASSERT_NEXT(a_end_closes, clk, rst_n, proc && in_reg.stream_end,
        !open_reg, "group left open after stream end")
    `SSOC_ASSERT_NEXT(a_pop_drains, clk, rst_n, pop && !proc,
        count_reg == $past(count_reg) - CNT_W'(1), "queue count lost a result")

endmodule

### dv/sorted_set_operation_counter_test.sv
// Self-checking testbench for sorted_set_operation_counter: runs of equal keys, random
// operations, random gaps and stalls, with results checked against an in-bench predictor.
// Depends on ssoc_pkg and the sorted_set_operation_counter RTL.
module sorted_set_operation_counter_test;

    typedef logic [ssoc_pkg::OP_WIDTH-1:0] op_t;

    localparam op_t  OP_RESERVED_5 = 3'd5;
    localparam op_t  OP_RESERVED_6 = 3'd6;
    localparam op_t  OP_RESERVED_7 = 3'd7;
    localparam logic SIDE_LEFT  = 1'b0;
    localparam logic SIDE_RIGHT = 1'b1;
    localparam int   RANDOM_TUPLES    = 1100;
    localparam int   PRESSURE_TUPLES  = 40;
    localparam int   PRESSURE_TRIGGER = 10;
    localparam int   DRAIN_CYCLES     = 6;
    localparam int   HOLD_OFF         = 150;
    localparam int   WATCHDOG_LIMIT   = 4000;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                cfg_write    = 1'b0;
    op_t                 cfg_data     = '0;
    logic                tuple_valid  = 1'b0;
    logic                tuple_stall;
    ssoc_pkg::tuple_t    tuple_data   = '0;
    logic                result_valid;
    logic                result_stall = 1'b1;
    ssoc_pkg::result_t   result_data;

    ssoc_pkg::tuple_t  pending_tuples[$];
    ssoc_pkg::result_t expected_groups[$];

    op_t         active_op   = ssoc_pkg::OP_INTERSECT;
    logic [31:0] run_key     = '0;
    logic [31:0] left_rows   = '0;
    logic [31:0] right_rows  = '0;
    logic        run_open    = 1'b0;

    int mismatch_count = 0;
    int results_taken  = 0;
    int hold_off_left  = 0;
    int tx_gap         = 0;
    int tx_steady      = 0;
    int rx_run         = 0;
    int idle_cycles    = 0;

    sorted_set_operation_counter u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .tuple_valid  (tuple_valid),
        .tuple_stall  (tuple_stall),
        .tuple_data   (tuple_data),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_data  (result_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] group_copies(input op_t op,
                                                 input logic [31:0] l, input logic [31:0] r);
        case (op)
            ssoc_pkg::OP_INTERSECT:     return (l != 0 && r != 0) ? 32'd1 : 32'd0;
            ssoc_pkg::OP_INTERSECT_ALL: return (l < r) ? l : r;
            ssoc_pkg::OP_EXCEPT:        return (l != 0 && r == 0) ? 32'd1 : 32'd0;
            ssoc_pkg::OP_EXCEPT_ALL:    return (l >= r) ? l - r : 32'd0;
            ssoc_pkg::OP_COMBINE:       return 32'd1;
            default:                    return 32'd0;
        endcase
    endfunction

    task automatic close_run(inout int emitted);
        ssoc_pkg::result_t res;
        logic [31:0]       n;
        n = group_copies(active_op, left_rows, right_rows);
        run_open = 1'b0;
        if (n != 0)
        begin
            res.result_key = run_key;
            res.copies     = n;
            res.end_of_run = 1'b0;
            expected_groups.push_back(res);
            emitted++;
        end
    endtask

    task automatic predict_tuple(input ssoc_pkg::tuple_t t);
        int emitted;
        emitted = 0;
        if (run_open && t.group_key != run_key)
            close_run(emitted);
        if (!run_open)
        begin
            run_key    = t.group_key;
            left_rows  = '0;
            right_rows = '0;
            run_open   = 1'b1;
        end
        if (t.side == SIDE_RIGHT)
            right_rows = (right_rows == '1) ? right_rows : right_rows + 32'd1;
        else
            left_rows = (left_rows == '1) ? left_rows : left_rows + 32'd1;
        if (t.stream_end)
            close_run(emitted);
        if (emitted > 0)
            expected_groups[expected_groups.size() - 1].end_of_run = 1'b1;
    endtask

    always @(posedge clk)
    begin : tuple_driver
        logic             next_valid;
        ssoc_pkg::tuple_t next_data;
        if (rst_n)
        begin
            next_valid = tuple_valid;
            next_data  = tuple_data;
            if (tuple_valid && !tuple_stall)
            begin
                predict_tuple(tuple_data);
                next_valid = 1'b0;
                tx_gap = (hold_off_left > 0 || tx_steady > 0) ? 0 : pick_gap();
                if (tx_steady > 0)
                    tx_steady--;
                else if ($urandom_range(0, 99) < 3)
                    tx_steady = $urandom_range(20, 60);
            end
            if (!next_valid)
            begin
                if (tx_gap > 0)
                    tx_gap--;
                else if (pending_tuples.size() != 0)
                begin
                    next_data  = pending_tuples.pop_front();
                    next_valid = 1'b1;
                end
            end
            tuple_valid <= next_valid;
            tuple_data  <= next_data;
        end
    end

    always @(posedge clk)
    begin : result_monitor
        logic              next_stall;
        ssoc_pkg::result_t want;
        int                r;
        if (rst_n)
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_groups.size() == 0)
                begin
                    $error("unexpected result transaction: key %h copies %0d",
                           result_data.result_key, result_data.copies);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_groups.pop_front();
                    if (result_data.result_key !== want.result_key)
                    begin
                        $error("result_key expected %h actual %h",
                               want.result_key, result_data.result_key);
                        mismatch_count++;
                    end
                    if (result_data.copies !== want.copies)
                    begin
                        $error("copies expected %0d actual %0d", want.copies, result_data.copies);
                        mismatch_count++;
                    end
                    if (result_data.end_of_run !== want.end_of_run)
                    begin
                        $error("end_of_run expected %b actual %b",
                               want.end_of_run, result_data.end_of_run);
                        mismatch_count++;
                    end
                end
                results_taken++;
                if (results_taken == PRESSURE_TRIGGER || results_taken == 120)
                    hold_off_left = HOLD_OFF;
            end
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                next_stall = 1'b1;
            end
            else if (rx_run > 0)
            begin
                rx_run--;
                next_stall = result_stall;
            end
            else
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    next_stall = 1'b1;
                    rx_run     = pick_gap();
                end
                else if (r < 34)
                begin
                    next_stall = 1'b0;
                    rx_run     = $urandom_range(40, 100);
                end
                else
                begin
                    next_stall = 1'b0;
                    rx_run     = $urandom_range(0, 12);
                end
            end
            result_stall <= next_stall;
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (rst_n)
        begin
            if ((tuple_valid && !tuple_stall) || (result_valid && !result_stall) || cfg_write)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    task automatic write_operation(input op_t op);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= op;
        @(posedge clk);
        cfg_write <= 1'b0;
        active_op = op;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (pending_tuples.size() != 0 || tuple_valid || expected_groups.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    initial
    begin : stimulus
        op_t              dir_ops[8];
        op_t              op;
        logic [31:0]      key;
        ssoc_pkg::tuple_t row;
        int               total;
        int               phase_len;
        int               run_len;
        int               side_mode;
        int               n;
        int               r;
        dir_ops = '{ssoc_pkg::OP_INTERSECT, ssoc_pkg::OP_INTERSECT_ALL, ssoc_pkg::OP_EXCEPT,
                    ssoc_pkg::OP_EXCEPT_ALL, ssoc_pkg::OP_COMBINE, OP_RESERVED_5,
                    OP_RESERVED_6, OP_RESERVED_7};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // extreme keys, both sides, a double close on one tuple, reopen after stream end
        foreach (dir_ops[i])
        begin
            write_operation(dir_ops[i]);
            @(negedge clk);
            pending_tuples.push_back(ssoc_pkg::tuple_t'{32'h0000_0000, SIDE_LEFT, 1'b0});
            pending_tuples.push_back(ssoc_pkg::tuple_t'{32'h0000_0000, SIDE_RIGHT, 1'b0});
            pending_tuples.push_back(ssoc_pkg::tuple_t'{32'hFFFF_FFFF, SIDE_LEFT, 1'b1});
            if (dir_ops[i] == ssoc_pkg::OP_COMBINE)
                pending_tuples.push_back(ssoc_pkg::tuple_t'{32'hFFFF_FFFF, SIDE_RIGHT, 1'b1});
            wait_drained();
        end

        // one result per tuple so that a receiver hold-off fills the block
        write_operation(ssoc_pkg::OP_COMBINE);
        @(negedge clk);
        for (int i = 0; i < PRESSURE_TUPLES; i++)
        begin
            row.group_key  = $urandom;
            row.side       = SIDE_LEFT;
            row.stream_end = 1'b1;
            pending_tuples.push_back(row);
        end
        wait_drained();

        total = 0;
        key   = '0;
        while (total < RANDOM_TUPLES)
        begin
            if ($urandom_range(0, 99) < 85)
                op = op_t'($urandom_range(ssoc_pkg::OP_INTERSECT, ssoc_pkg::OP_COMBINE));
            else
                op = op_t'($urandom_range(OP_RESERVED_5, OP_RESERVED_7));
            write_operation(op);
            phase_len = $urandom_range(100, 150);
            @(negedge clk);
            n = 0;
            while (n < phase_len)
            begin
                r = $urandom_range(0, 99);
                if (r < 10)
                    key = key;
                else if (r < 13)
                    key = '0;
                else if (r < 16)
                    key = '1;
                else
                    key = $urandom;
                r = $urandom_range(0, 99);
                if (r < 70)
                    run_len = $urandom_range(1, 4);
                else if (r < 95)
                    run_len = $urandom_range(5, 12);
                else
                    run_len = $urandom_range(13, 40);
                side_mode = $urandom_range(0, 3);
                for (int i = 0; i < run_len; i++)
                begin
                    row.group_key = key;
                    case (side_mode)
                        0:       row.side = SIDE_LEFT;
                        1:       row.side = SIDE_RIGHT;
                        2:       row.side = 1'($urandom_range(0, 1));
                        default: row.side = ($urandom_range(0, 3) == 0) ? SIDE_RIGHT : SIDE_LEFT;
                    endcase
                    if (i == run_len - 1)
                        row.stream_end = ($urandom_range(0, 99) < 15);
                    else
                        row.stream_end = ($urandom_range(0, 99) < 2);
                    pending_tuples.push_back(row);
                end
                n += run_len;
            end
            total += n;
            wait_drained();
        end

        if (mismatch_count == 0 && expected_groups.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

### files.f
+incdir+rtl/core
rtl/core/ssoc_pkg.sv
rtl/core/ssoc_copies.sv
rtl/core/sorted_set_operation_counter.sv
dv/sorted_set_operation_counter_test.sv
